/* src/drt_pkg.sv */
package drt_pkg;

    localparam int COORD_BITS = 10;
    localparam int WIN_BITS   = COORD_BITS + 1;
    localparam int POS_BITS   = 12;
    localparam int LEN_BITS   = 12;
    localparam int SIZE_BITS  = 10;
    localparam int OFS_BITS   = 8;
    localparam int CFG_BITS   = 10;
    localparam int CFG_IDX_BITS = 2;
    // wide enough for pos + len - 1 and for any saturated screen limit
    localparam int SUM_BITS   = 17;

    localparam logic [SIZE_BITS-1:0] SCREEN_W_RST = SIZE_BITS'(240);
    localparam logic [SIZE_BITS-1:0] SCREEN_H_RST = SIZE_BITS'(320);

    typedef enum logic [1:0] {
        MODE_MARK   = 2'd0,
        MODE_START  = 2'd1,
        MODE_END    = 2'd2,
        MODE_TAKE   = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SCREEN_W = 2'd0,
        CFG_SCREEN_H = 2'd1,
        CFG_OFS_X    = 2'd2,
        CFG_OFS_Y    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                  hit;
        logic [COORD_BITS-1:0] lo;
        logic [COORD_BITS-1:0] hi;
    } t_span;

    typedef struct packed {
        logic                  region_valid;
        logic                  update_pending;
        logic                  send_now;
        logic [COORD_BITS-1:0] box_left;
        logic [COORD_BITS-1:0] box_top;
        logic [COORD_BITS-1:0] box_right;
        logic [COORD_BITS-1:0] box_bottom;
        logic [WIN_BITS-1:0]   window_left;
        logic [WIN_BITS-1:0]   window_top;
        logic [WIN_BITS-1:0]   window_right;
        logic [WIN_BITS-1:0]   window_bottom;
    } t_result;

endpackage

/* src/drt_in_if.sv */
interface drt_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             mode;
    logic signed [drt_pkg::POS_BITS-1:0]    rect_x;
    logic signed [drt_pkg::POS_BITS-1:0]    rect_y;
    logic [drt_pkg::LEN_BITS-1:0]           rect_w;
    logic [drt_pkg::LEN_BITS-1:0]           rect_h;

    modport source (output valid, mode, rect_x, rect_y, rect_w, rect_h, input ready);
    modport sink   (input valid, mode, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

/* src/drt_out_if.sv */
interface drt_out_if;
    logic                               valid;
    logic                               ready;
    logic                               region_valid;
    logic                               update_pending;
    logic                               send_now;
    logic [drt_pkg::COORD_BITS-1:0]     box_left;
    logic [drt_pkg::COORD_BITS-1:0]     box_top;
    logic [drt_pkg::COORD_BITS-1:0]     box_right;
    logic [drt_pkg::COORD_BITS-1:0]     box_bottom;
    logic [drt_pkg::WIN_BITS-1:0]       window_left;
    logic [drt_pkg::WIN_BITS-1:0]       window_top;
    logic [drt_pkg::WIN_BITS-1:0]       window_right;
    logic [drt_pkg::WIN_BITS-1:0]       window_bottom;

    modport source (output valid, region_valid, update_pending, send_now,
                    box_left, box_top, box_right, box_bottom,
                    window_left, window_top, window_right, window_bottom,
                    input ready);
    modport sink   (input valid, region_valid, update_pending, send_now,
                    box_left, box_top, box_right, box_bottom,
                    window_left, window_top, window_right, window_bottom,
                    output ready);
endinterface

/* src/drt_clamp.sv */
module drt_clamp (
    input  logic signed [drt_pkg::POS_BITS-1:0] i_pos,
    input  logic [drt_pkg::LEN_BITS-1:0]        i_len,
    input  logic [drt_pkg::SIZE_BITS-1:0]       i_size,
    output drt_pkg::t_span                      o_span
);
    import drt_pkg::*;

    localparam logic signed [SUM_BITS-1:0] ONE_S  = SUM_BITS'(1);
    localparam logic signed [SUM_BITS-1:0] ZERO_S = '0;
    localparam logic signed [SUM_BITS-1:0] MASK_S = SUM_BITS'((1 << COORD_BITS) - 1);

    logic signed [SUM_BITS-1:0] pos_s;
    logic signed [SUM_BITS-1:0] size_s;
    logic signed [SUM_BITS-1:0] end_s;
    logic signed [SUM_BITS-1:0] lim_s;
    logic signed [SUM_BITS-1:0] lo_s;
    logic signed [SUM_BITS-1:0] hi_s;

    always_comb begin
        pos_s  = SUM_BITS'(i_pos);
        size_s = $signed(SUM_BITS'(i_size));
        end_s  = pos_s + $signed(SUM_BITS'(i_len)) - ONE_S;
        // saturate screen size to the coordinate range; size zero gives -1
        lim_s  = (size_s > MASK_S) ? (MASK_S - ONE_S) : (size_s - ONE_S);
        lo_s   = (pos_s < ZERO_S) ? ZERO_S : pos_s;
        hi_s   = (end_s > lim_s) ? lim_s : end_s;

        o_span.hit = !(lo_s > hi_s);
        o_span.lo  = lo_s[COORD_BITS-1:0];
        o_span.hi  = hi_s[COORD_BITS-1:0];
    end

endmodule

/* src/dirty_region_tracker.sv */
// An accepted command's result goes to the output register, or to the skid
// register if the output register holds a result that is not yet taken.
// Throughput: one command per cycle while the skid register is empty; this
// two-entry output stage keeps input ready while one result waits downstream.
// Reset (synchronous, active low) clears the box, update-pending and both
// output entries, and loads screen 240 x 320 with zero panel offsets.
module dirty_region_tracker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [drt_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [drt_pkg::CFG_BITS-1:0]     i_cfg_data,
    drt_in_if.sink                           i_cmd,
    drt_out_if.source                        o_res
);
    import drt_pkg::*;

    logic [SIZE_BITS-1:0]  r_screen_w;
    logic [SIZE_BITS-1:0]  r_screen_h;
    logic [OFS_BITS-1:0]   r_ofs_x;
    logic [OFS_BITS-1:0]   r_ofs_y;

    logic                  r_box_valid, n_box_valid;
    logic                  r_pending,   n_pending;
    logic [COORD_BITS-1:0] r_left,   n_left;
    logic [COORD_BITS-1:0] r_top,    n_top;
    logic [COORD_BITS-1:0] r_right,  n_right;
    logic [COORD_BITS-1:0] r_bottom, n_bottom;

    logic                  r_out_valid;
    t_result               r_out;
    logic                  r_skid_valid;
    t_result               r_skid;

    t_span                 span_x;
    t_span                 span_y;
    t_mode                 cmd_mode;
    logic                  send;
    logic                  accept;
    t_result               res;

    drt_clamp u_clamp_x (
        .i_pos  (i_cmd.rect_x),
        .i_len  (i_cmd.rect_w),
        .i_size (r_screen_w),
        .o_span (span_x)
    );

    drt_clamp u_clamp_y (
        .i_pos  (i_cmd.rect_y),
        .i_len  (i_cmd.rect_h),
        .i_size (r_screen_h),
        .o_span (span_y)
    );

    assign cmd_mode    = t_mode'(i_cmd.mode);
    assign i_cmd.ready = !r_skid_valid;
    assign accept      = i_cmd.valid && !r_skid_valid;

    always_comb begin
        n_box_valid = r_box_valid;
        n_pending   = r_pending;
        n_left      = r_left;
        n_top       = r_top;
        n_right     = r_right;
        n_bottom    = r_bottom;
        send        = 1'b0;
        unique case (cmd_mode)
            MODE_MARK: begin
                if (span_x.hit && span_y.hit) begin
                    if (!r_box_valid) begin
                        n_left   = span_x.lo;
                        n_top    = span_y.lo;
                        n_right  = span_x.hi;
                        n_bottom = span_y.hi;
                    end else begin
                        n_left   = (span_x.lo < r_left)   ? span_x.lo : r_left;
                        n_top    = (span_y.lo < r_top)    ? span_y.lo : r_top;
                        n_right  = (span_x.hi > r_right)  ? span_x.hi : r_right;
                        n_bottom = (span_y.hi > r_bottom) ? span_y.hi : r_bottom;
                    end
                    n_box_valid = 1'b1;
                end
            end
            MODE_START: begin
                n_box_valid = 1'b0;
            end
            MODE_END: begin
                if (r_box_valid) begin
                    n_pending = 1'b1;
                end
            end
            MODE_TAKE: begin
                send      = r_pending && r_box_valid;
                n_pending = 1'b0;
            end
            default: begin
                n_box_valid = r_box_valid;
            end
        endcase
    end

    always_comb begin
        res                = '0;
        res.region_valid   = n_box_valid;
        res.update_pending = n_pending;
        res.send_now       = send;
        if (n_box_valid) begin
            res.box_left   = n_left;
            res.box_top    = n_top;
            res.box_right  = n_right;
            res.box_bottom = n_bottom;
        end
        if (send) begin
            res.window_left   = WIN_BITS'(n_left)   + WIN_BITS'(r_ofs_x);
            res.window_top    = WIN_BITS'(n_top)    + WIN_BITS'(r_ofs_y);
            res.window_right  = WIN_BITS'(n_right)  + WIN_BITS'(r_ofs_x);
            res.window_bottom = WIN_BITS'(n_bottom) + WIN_BITS'(r_ofs_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= SCREEN_W_RST;
            r_screen_h <= SCREEN_H_RST;
            r_ofs_x    <= '0;
            r_ofs_y    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SCREEN_W: r_screen_w <= i_cfg_data[SIZE_BITS-1:0];
                CFG_SCREEN_H: r_screen_h <= i_cfg_data[SIZE_BITS-1:0];
                CFG_OFS_X:    r_ofs_x    <= i_cfg_data[OFS_BITS-1:0];
                CFG_OFS_Y:    r_ofs_y    <= i_cfg_data[OFS_BITS-1:0];
                default:      r_ofs_y    <= r_ofs_y;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_valid <= 1'b0;
            r_pending   <= 1'b0;
            r_left      <= '0;
            r_top       <= '0;
            r_right     <= '0;
            r_bottom    <= '0;
        end else if (accept) begin
            r_box_valid <= n_box_valid;
            r_pending   <= n_pending;
            r_left      <= n_left;
            r_top       <= n_top;
            r_right     <= n_right;
            r_bottom    <= n_bottom;
        end
    end

    // output register with a skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            if (!r_out_valid || o_res.ready) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid       <= res;
            end
        end else if (r_out_valid && o_res.ready) begin
            // advance the skid entry, if any
            r_out_valid  <= r_skid_valid;
            r_out        <= r_skid;
            r_skid_valid <= 1'b0;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.region_valid   = r_out.region_valid;
    assign o_res.update_pending = r_out.update_pending;
    assign o_res.send_now       = r_out.send_now;
    assign o_res.box_left       = r_out.box_left;
    assign o_res.box_top        = r_out.box_top;
    assign o_res.box_right      = r_out.box_right;
    assign o_res.box_bottom     = r_out.box_bottom;
    assign o_res.window_left    = r_out.window_left;
    assign o_res.window_top     = r_out.window_top;
    assign o_res.window_right   = r_out.window_right;
    assign o_res.window_bottom  = r_out.window_bottom;

endmodule
